### hw/rtl/bbf_pkg.sv
`timescale 1ns / 1ps
// Package for the bounded byte FIFO: request codes, request and result payloads,
// decoded command and status types, and the back-end state encoding.
// No dependencies.
package bbf_pkg;

    // Request codes as they arrive on the request channel
    localparam logic [2:0] REQ_WRITE = 3'd0;
    localparam logic [2:0] REQ_PEEK  = 3'd1;
    localparam logic [2:0] REQ_POP   = 3'd2;
    localparam logic [2:0] REQ_READ  = 3'd3;
    localparam logic [2:0] REQ_END   = 3'd4;

    // Capacity register value after reset
    localparam logic [10:0] CAP_RESET = 11'd1024;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_PEEK,
        OP_POP,
        OP_READ,
        OP_END
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BURST,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] data_byte;
        logic [6:0] length;
    } req_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        logic        write_accepted;
        logic        error_flag;
        logic [10:0] fill_count;
        logic [47:0] total_written;
        logic [47:0] total_read;
        logic        input_closed;
        logic        at_eof;
    } rsp_t;

    // Request after decode, with the length already clamped to the burst limit
    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic [6:0] length;
    } cmd_t;

    // Status carried by every result of a request
    typedef struct packed {
        logic        error_flag;
        logic [10:0] fill_count;
        logic [47:0] total_written;
        logic [47:0] total_read;
        logic        input_closed;
        logic        at_eof;
    } stat_t;

endpackage

### hw/rtl/bbf_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interface used for the request and result channels.
// The payload type is given per instance; no package dependency.
interface bbf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

### hw/rtl/bbf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module bbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
)
(
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Store on write enable
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register read data, hold it between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bbf_front.sv
`timescale 1ns / 1ps
// Front end of the byte FIFO: accept requests, decode and clamp them, and
// hold them in a two-entry command queue. Depends on bbf_pkg and bbf_stream_if.
module bbf_front
    import bbf_pkg::*;
#(
    parameter int MAX_BURST = 64
)
(
    input  logic   clk,
    input  logic   rst_n,
    bbf_stream_if.sink req,
    output logic   cmd_valid,
    input  logic   cmd_ready,
    output cmd_t   cmd
);

    localparam logic [6:0] BURST_MAX = 7'(MAX_BURST);

    cmd_t       dec_cmd;
    cmd_t       q_reg [2];
    logic       q_wr_ptr_reg;
    logic       q_wr_ptr_next;
    logic       q_rd_ptr_reg;
    logic       q_rd_ptr_next;
    logic [1:0] q_cnt_reg;
    logic [1:0] q_cnt_next;
    logic       push;
    logic       pop;

    // Decode the request code and clamp the length to the burst limit
    always_comb
    begin
        dec_cmd.data_byte = req.payload.data_byte;
        dec_cmd.length    = (req.payload.length > BURST_MAX) ? BURST_MAX
                                                             : req.payload.length;
        case (req.payload.req_type)
            REQ_WRITE: dec_cmd.op = OP_WRITE;
            REQ_PEEK:  dec_cmd.op = OP_PEEK;
            REQ_POP:   dec_cmd.op = OP_POP;
            REQ_READ:  dec_cmd.op = OP_READ;
            REQ_END:   dec_cmd.op = OP_END;
            default:   dec_cmd.op = OP_NONE;
        endcase
    end

    // Queue handshakes
    assign req.ready = (q_cnt_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (q_cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[q_rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        q_wr_ptr_next = push ? ~q_wr_ptr_reg : q_wr_ptr_reg;
        q_rd_ptr_next = pop ? ~q_rd_ptr_reg : q_rd_ptr_reg;
        q_cnt_next    = q_cnt_reg;
        if (push && !pop)
        begin
            q_cnt_next = q_cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            q_cnt_next = q_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
            q_cnt_reg    <= 2'd0;
        end
        else
        begin
            q_wr_ptr_reg <= q_wr_ptr_next;
            q_rd_ptr_reg <= q_rd_ptr_next;
            q_cnt_reg    <= q_cnt_next;
        end
    end

    // Store the decoded request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[q_wr_ptr_reg] <= dec_cmd;
        end
    end

`ifndef SYNTHESIS
    a_q_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_cnt_reg != 2'd3)
        else $error("command queue count out of range");
    a_q_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_ready) |=> cmd_valid)
        else $error("queued command lost while back end stalled");
`endif

endmodule

### hw/rtl/bbf_back.sv
`timescale 1ns / 1ps
// Back end of the byte FIFO: execute decoded requests against the byte store,
// keep fill, pointers and totals, and drive the result register.
// Depends on bbf_pkg, bbf_stream_if and bbf_ram.
module bbf_back
    import bbf_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [10:0] capacity,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    bbf_stream_if.source rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = (AW + 1 > 11) ? AW + 1 : 11;
    localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);
    localparam logic [10:0]   DEPTH_CAP = (DEPTH > 2047) ? 11'd2047 : 11'(DEPTH);

    // Add to a store pointer and wrap at the store depth
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] ptr,
                                               input logic [10:0]   amt);
        logic [SW-1:0] sum;
        sum = SW'(ptr) + SW'(amt);
        if (sum >= DEPTH_S)
        begin
            sum = sum - DEPTH_S;
        end
        return sum[AW-1:0];
    endfunction

    state_t      state_reg;
    state_t      state_next;
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] tail_reg;
    logic [AW-1:0] tail_next;
    logic [10:0] fill_reg;
    logic [10:0] fill_next;
    logic [47:0] wtot_reg;
    logic [47:0] wtot_next;
    logic [47:0] rtot_reg;
    logic [47:0] rtot_next;
    logic        ended_reg;
    logic        ended_next;
    logic        err_reg;
    logic        err_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [6:0]  n_reg;
    logic [6:0]  n_next;
    logic [6:0]  cnt_reg;
    logic [6:0]  cnt_next;
    logic        rd_pend_reg;
    logic        rd_pend_next;
    logic        pend_last_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    rsp_t        out_reg;
    stat_t       stat_reg;
    stat_t       stat_now;

    logic [10:0] eff_cap;
    logic        out_free;
    logic        take;
    logic        issue;
    logic        load_byte;
    logic        load_stat;
    logic        last_issue;
    logic        len_big;
    logic [6:0]  rd_n;
    logic [6:0]  burst_n;
    logic        accepted;
    logic        ram_we;
    logic [7:0]  ram_rdata;

    // Limit capacity to the store depth
    assign eff_cap  = (capacity > DEPTH_CAP) ? DEPTH_CAP : capacity;
    assign out_free = !out_valid_reg || rsp.ready;

    // Handshake and strobe outputs of the control FSM
    always_comb
    begin
        cmd_ready = (state_reg == ST_IDLE) && out_free;
        take      = cmd_valid && cmd_ready;
        issue     = (state_reg == ST_BURST) && (!rd_pend_reg || out_free);
        load_byte = rd_pend_reg && out_free;
    end

    // Status result for requests that deliver no byte
    assign load_stat  = take && (burst_n == 7'd0);
    assign last_issue = (cnt_reg == n_reg - 7'd1);

    // Next state of the control FSM
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && (burst_n != 7'd0))
                begin
                    state_next = ST_BURST;
                end
            end
            ST_BURST:
            begin
                if (issue && last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (load_byte)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Execute the request taken from the queue and commit its effect at once
    assign len_big = ({4'd0, cmd.length} > fill_reg);
    assign rd_n    = len_big ? fill_reg[6:0] : cmd.length;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        wtot_next  = wtot_reg;
        rtot_next  = rtot_reg;
        ended_next = ended_reg;
        err_next   = err_reg;
        accepted   = 1'b0;
        ram_we     = 1'b0;
        burst_n    = 7'd0;
        if (take)
        begin
            case (cmd.op)
                OP_WRITE:
                begin
                    if (fill_reg < eff_cap)
                    begin
                        ram_we    = 1'b1;
                        tail_next = wrap_add(tail_reg, 11'd1);
                        fill_next = fill_reg + 11'd1;
                        wtot_next = wtot_reg + 48'd1;
                        accepted  = 1'b1;
                    end
                end
                OP_PEEK:
                begin
                    burst_n = rd_n;
                end
                OP_POP, OP_READ:
                begin
                    if (cmd.op == OP_READ)
                    begin
                        burst_n = rd_n;
                    end
                    if (len_big)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        head_next = wrap_add(head_reg, {4'd0, cmd.length});
                        fill_next = fill_reg - {4'd0, cmd.length};
                        rtot_next = rtot_reg + 48'(cmd.length);
                    end
                end
                OP_END:
                begin
                    ended_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Status after the whole request
    always_comb
    begin
        stat_now.error_flag    = err_next;
        stat_now.fill_count    = fill_next;
        stat_now.total_written = wtot_next;
        stat_now.total_read    = rtot_next;
        stat_now.input_closed  = ended_next;
        stat_now.at_eof        = ended_next && (fill_next == 11'd0);
    end

    // Burst read pointer, counters and read-pending flag
    always_comb
    begin
        rd_ptr_next  = rd_ptr_reg;
        n_next       = n_reg;
        cnt_next     = cnt_reg;
        if (take)
        begin
            rd_ptr_next = head_reg;
            n_next      = burst_n;
            cnt_next    = 7'd0;
        end
        else if (issue)
        begin
            rd_ptr_next = wrap_add(rd_ptr_reg, 11'd1);
            cnt_next    = cnt_reg + 7'd1;
        end

        if (issue)
        begin
            rd_pend_next = 1'b1;
        end
        else if (load_byte)
        begin
            rd_pend_next = 1'b0;
        end
        else
        begin
            rd_pend_next = rd_pend_reg;
        end

        if (load_stat || load_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= 11'd0;
            wtot_reg      <= 48'd0;
            rtot_reg      <= 48'd0;
            ended_reg     <= 1'b0;
            err_reg       <= 1'b0;
            rd_ptr_reg    <= '0;
            n_reg         <= 7'd0;
            cnt_reg       <= 7'd0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            wtot_reg      <= wtot_next;
            rtot_reg      <= rtot_next;
            ended_reg     <= ended_next;
            err_reg       <= err_next;
            rd_ptr_reg    <= rd_ptr_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the request status and the last mark of the byte in flight
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stat_reg <= stat_now;
        end
        if (issue)
        begin
            pend_last_reg <= last_issue;
        end
    end

    // Load the result register from a status result or a delivered byte
    always_ff @(posedge clk)
    begin
        if (load_stat)
        begin
            out_reg.out_byte       <= 8'd0;
            out_reg.byte_valid     <= 1'b0;
            out_reg.last           <= 1'b1;
            out_reg.write_accepted <= accepted;
            out_reg.error_flag     <= stat_now.error_flag;
            out_reg.fill_count     <= stat_now.fill_count;
            out_reg.total_written  <= stat_now.total_written;
            out_reg.total_read     <= stat_now.total_read;
            out_reg.input_closed   <= stat_now.input_closed;
            out_reg.at_eof         <= stat_now.at_eof;
        end
        else if (load_byte)
        begin
            out_reg.out_byte       <= ram_rdata;
            out_reg.byte_valid     <= 1'b1;
            out_reg.last           <= pend_last_reg;
            out_reg.write_accepted <= 1'b0;
            out_reg.error_flag     <= stat_reg.error_flag;
            out_reg.fill_count     <= stat_reg.fill_count;
            out_reg.total_written  <= stat_reg.total_written;
            out_reg.total_read     <= stat_reg.total_read;
            out_reg.input_closed   <= stat_reg.input_closed;
            out_reg.at_eof         <= stat_reg.at_eof;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    // Byte store
    bbf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (cmd.data_byte),
        .re    (issue),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_pend_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg != ST_IDLE))
        else $error("byte read pending while idle");
    a_drain_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> rd_pend_reg)
        else $error("drain state without a byte in flight");
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("sticky error cleared");
    a_fill_totals: assert property (@(posedge clk) disable iff (!rst_n)
        (wtot_reg - rtot_reg) == 48'(fill_reg))
        else $error("fill does not match written minus read totals");
`endif

endmodule

### hw/rtl/bounded_byte_stream_fifo_core.sv
`timescale 1ns / 1ps
// Top level of the bounded byte FIFO: capacity register, front end and back end.
// Depends on bbf_pkg, bbf_stream_if, bbf_front, bbf_back and bbf_ram.
//
// Usage:
//   req  - request channel (valid/ready, req_t): write, peek, pop, read, end input.
//   rsp  - result channel (valid/ready, rsp_t): one result per write, pop, end input
//          or empty peek/read; one result per delivered byte for peek and read, the
//          final result of each request marked with last.
//   cfg_we/cfg_wdata - capacity register write, taken on any clock with cfg_we high;
//          write it only while no request is in flight.
// Path: a status result goes from the command queue into the result register; a
//   peek or read byte goes from the queue via the burst read pointer and the
//   registered store read into the result register. Throughput: the back end takes
//   a write, pop or end input once the result register is free; a peek or read holds
//   it until its last byte is loaded, one byte per cycle while results are taken.
// A two-entry command queue keeps accepting requests while the back end works.
// When the receiver stalls, the result register holds and the back end and then
//   the queue fill up and stop.
// Reset empties the FIFO, clears totals and flags and sets capacity to 1024; the
//   byte store needs no clearing pass.
module bounded_byte_stream_fifo_core
    import bbf_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    bbf_stream_if.sink   req,
    bbf_stream_if.source rsp
);

    logic [10:0] capacity_reg;
    logic [10:0] capacity_next;
    logic        cmd_valid;
    logic        cmd_ready;
    cmd_t        cmd;

    // Capacity register
    assign capacity_next = cfg_we ? cfg_wdata : capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    bbf_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    bbf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp       (rsp)
    );

endmodule

### dv/bounded_byte_stream_fifo_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded byte FIFO core: directed table, then random requests
// with random stalls, checked result by result against a behavioral copy of the FIFO.
// Depends on bbf_pkg, bbf_stream_if and bounded_byte_stream_fifo_core.
module bounded_byte_stream_fifo_core_test
    import bbf_pkg::*;
();

    localparam int DEPTH         = 1024;
    localparam int MAX_BURST     = 64;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_ITEMS   = 16;
    localparam int PRINT_LIMIT   = 30;

    // Request codes the block does not define
    localparam logic [2:0] REQ_RSVD_A = 3'd5;
    localparam logic [2:0] REQ_RSVD_B = 3'd6;
    localparam logic [2:0] REQ_RSVD_C = 3'd7;

    typedef struct packed {
        logic        is_cap;
        logic [10:0] cap;
        req_t        r;
        logic        typed;
        rsp_t        want;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [10:0] cfg_wdata;

    bbf_stream_if #(.T(req_t)) req_ch ();
    bbf_stream_if #(.T(rsp_t)) rsp_ch ();

    bounded_byte_stream_fifo_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Shadow copy of the FIFO
    logic [7:0]  shadow_mem [0:DEPTH-1];
    logic [9:0]  shadow_head    = '0;
    logic [10:0] shadow_fill    = '0;
    logic [47:0] shadow_written = '0;
    logic [47:0] shadow_read    = '0;
    logic        shadow_closed  = 1'b0;
    logic        shadow_err     = 1'b0;
    logic [10:0] shadow_cap     = CAP_RESET;

    rsp_t owed_results [$];

    int  mismatches    = 0;
    int  results_seen  = 0;
    int  requests_done = 0;
    int  cap_writes    = 0;
    int  send_stretch  = 0;
    bit  send_calm     = 1'b0;
    int  recv_stretch  = 0;
    bit  recv_calm     = 1'b0;
    bit  squeeze_req   = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Draw a per-item wait; every 16 items decide whether to run without waits
    function automatic int pick_gap(inout int stretch, inout bit calm);
        if (stretch == 0)
        begin
            stretch = 16;
            calm = ($urandom_range(0, 2) == 0);
        end
        stretch--;
        return calm ? 0 : int'($urandom_range(0, 8));
    endfunction

    // Pop len bytes from the head of the shadow FIFO
    task automatic drop_head(input logic [6:0] len);
        shadow_head    = shadow_head + 10'(len);
        shadow_fill    = shadow_fill - 11'(len);
        shadow_read    = shadow_read + 48'(len);
    endtask

    // Advance the shadow FIFO by one request and queue the results it owes
    task automatic fifo_apply(input req_t r);
        logic [6:0]  len;
        logic [10:0] cap_eff;
        logic [10:0] cnt;
        logic        accepted;
        logic [7:0]  burst [MAX_BURST];
        rsp_t        res;
        int          count;
        len      = (r.length > 7'(MAX_BURST)) ? 7'(MAX_BURST) : r.length;
        cap_eff  = (shadow_cap > 11'(DEPTH)) ? 11'(DEPTH) : shadow_cap;
        accepted = 1'b0;
        cnt      = '0;
        case (r.req_type)
            REQ_WRITE:
            begin
                if (shadow_fill < cap_eff)
                begin
                    shadow_mem[shadow_head + 10'(shadow_fill)] = r.data_byte;
                    shadow_fill    = shadow_fill + 11'd1;
                    shadow_written = shadow_written + 48'd1;
                    accepted       = 1'b1;
                end
            end
            REQ_PEEK, REQ_READ:
            begin
                cnt = (11'(len) < shadow_fill) ? 11'(len) : shadow_fill;
                for (int i = 0; i < int'(cnt); i++)
                    burst[i] = shadow_mem[shadow_head + 10'(i)];
                if (r.req_type == REQ_READ)
                begin
                    if (11'(len) > shadow_fill)
                        shadow_err = 1'b1;
                    else
                        drop_head(len);
                end
            end
            REQ_POP:
            begin
                if (11'(len) > shadow_fill)
                    shadow_err = 1'b1;
                else
                    drop_head(len);
            end
            REQ_END:
                shadow_closed = 1'b1;
            default:
                ;
        endcase

        // Every result carries the status after the whole request
        count = (cnt == 11'd0) ? 1 : int'(cnt);
        for (int k = 0; k < count; k++)
        begin
            res = '0;
            if (cnt != 11'd0)
            begin
                res.out_byte   = burst[k];
                res.byte_valid = 1'b1;
            end
            res.last           = (k == count - 1);
            res.write_accepted = accepted;
            res.error_flag     = shadow_err;
            res.fill_count     = shadow_fill;
            res.total_written  = shadow_written;
            res.total_read     = shadow_read;
            res.input_closed   = shadow_closed;
            res.at_eof         = shadow_closed && (shadow_fill == 11'd0);
            owed_results       = {owed_results, res};
        end
    endtask

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("result %0d: %s got %0h want %0h", results_seen, what, got, want);
    endtask

    // Compare one result with the oldest one owed
    task automatic check_result(input rsp_t got);
        rsp_t want;
        results_seen++;
        if (owed_results.size() == 0)
            report_mismatch("result with nothing owed, fill", 48'(got.fill_count), '0);
        else
        begin
            want = owed_results[0];
            owed_results.delete(0);
            if (got.out_byte !== want.out_byte)
                report_mismatch("out_byte", 48'(got.out_byte), 48'(want.out_byte));
            if (got.byte_valid !== want.byte_valid)
                report_mismatch("byte_valid", 48'(got.byte_valid), 48'(want.byte_valid));
            if (got.last !== want.last)
                report_mismatch("last", 48'(got.last), 48'(want.last));
            if (got.write_accepted !== want.write_accepted)
                report_mismatch("write_accepted", 48'(got.write_accepted),
                                48'(want.write_accepted));
            if (got.error_flag !== want.error_flag)
                report_mismatch("error_flag", 48'(got.error_flag), 48'(want.error_flag));
            if (got.fill_count !== want.fill_count)
                report_mismatch("fill_count", 48'(got.fill_count), 48'(want.fill_count));
            if (got.total_written !== want.total_written)
                report_mismatch("total_written", got.total_written, want.total_written);
            if (got.total_read !== want.total_read)
                report_mismatch("total_read", got.total_read, want.total_read);
            if (got.input_closed !== want.input_closed)
                report_mismatch("input_closed", 48'(got.input_closed),
                                48'(want.input_closed));
            if (got.at_eof !== want.at_eof)
                report_mismatch("at_eof", 48'(got.at_eof), 48'(want.at_eof));
        end
    endtask

    // Offer one request, hold it until accepted, then predict its results
    task automatic offer_request(input req_t r, input logic typed, input rsp_t want);
        int gap;
        gap = pick_gap(send_stretch, send_calm);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        fifo_apply(r);
        // Hand-written expectation replaces the predicted one
        if (typed)
        begin
            owed_results[owed_results.size() - 1] = want;
        end
        requests_done++;
    endtask

    // Write the capacity once every owed result is in and the block has settled
    task automatic set_capacity(input logic [10:0] value);
        req_ch.valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        shadow_cap  = value;
        cap_writes++;
    endtask

    function automatic plan_row_t req_row(input logic [2:0] kind, input logic [7:0] data,
                                          input logic [6:0] len);
        plan_row_t row;
        row             = '0;
        row.r.req_type  = kind;
        row.r.data_byte = data;
        row.r.length    = len;
        return row;
    endfunction

    function automatic plan_row_t cap_row(input logic [10:0] value);
        plan_row_t row;
        row        = '0;
        row.is_cap = 1'b1;
        row.cap    = value;
        return row;
    endfunction

    // Status-only request with its single result written out by hand
    function automatic plan_row_t typed_row(input logic [2:0] kind, input logic [7:0] data,
                                            input logic [6:0] len, input logic wa,
                                            input logic err, input logic [10:0] fill,
                                            input logic [47:0] tw, input logic [47:0] tr,
                                            input logic closed, input logic eof);
        plan_row_t row;
        row                     = req_row(kind, data, len);
        row.typed               = 1'b1;
        row.want.last           = 1'b1;
        row.want.write_accepted = wa;
        row.want.error_flag     = err;
        row.want.fill_count     = fill;
        row.want.total_written  = tw;
        row.want.total_read     = tr;
        row.want.input_closed   = closed;
        row.want.at_eof         = eof;
        return row;
    endfunction

    // Random request shaped by the current fill: mostly lengths the FIFO can serve
    function automatic req_t draw_request();
        req_t r;
        int   roll;
        int   span;
        roll        = $urandom_range(0, 99);
        span        = (shadow_fill > 11'(MAX_BURST)) ? MAX_BURST : int'(shadow_fill);
        r.data_byte = 8'($urandom_range(0, 255));
        r.length    = 7'($urandom_range(0, span + 1));
        if (roll < 45)
            r.req_type = REQ_WRITE;
        else if (roll < 60)
            r.req_type = REQ_PEEK;
        else if (roll < 75)
            r.req_type = REQ_READ;
        else if (roll < 87)
            r.req_type = REQ_POP;
        else if (roll < 90)
            r.req_type = REQ_END;
        else if (roll < 96)
        begin
            // Oversized lengths, clamped by the block
            r.req_type = (roll < 93) ? REQ_READ : ((roll < 95) ? REQ_PEEK : REQ_POP);
            r.length   = 7'($urandom_range(0, 127));
        end
        else
            r.req_type = (roll == 96) ? REQ_RSVD_A : ((roll < 99) ? REQ_RSVD_B : REQ_RSVD_C);
        return r;
    endfunction

    // Result side: random waits, one long hold-off on request
    initial
    begin : result_sink
        int gap;
        rsp_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = pick_gap(recv_stretch, recv_calm);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
            check_result(rsp_ch.payload);
        end
    end

    // Watchdog: end the run when no handshake happens for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles, %0d results owed", idle,
                         owed_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        plan_row_t   plan [$];
        logic [10:0] phase_caps [6];
        int          directed;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rst_n          = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan = '{
            // empty FIFO: zero pop and peek are plain status
            typed_row(REQ_POP,  8'h00, 7'd0, 1'b0, 1'b0, 11'd0, 48'd0, 48'd0, 1'b0, 1'b0),
            typed_row(REQ_PEEK, 8'h00, 7'd5, 1'b0, 1'b0, 11'd0, 48'd0, 48'd0, 1'b0, 1'b0),
            typed_row(REQ_WRITE, 8'h00, 7'd0, 1'b1, 1'b0, 11'd1, 48'd1, 48'd0, 1'b0, 1'b0),
            req_row(REQ_WRITE, 8'hFF, 7'd0),
            req_row(REQ_WRITE, 8'hA5, 7'd0),
            // length above the burst limit, then clamped to the fill
            req_row(REQ_PEEK, 8'h00, 7'd127),
            req_row(REQ_READ, 8'h00, 7'd2),
            // pop beyond the fill raises the sticky error
            typed_row(REQ_POP, 8'h00, 7'd5, 1'b0, 1'b1, 11'd1, 48'd3, 48'd2, 1'b0, 1'b0),
            // read beyond the fill delivers what is held and removes nothing
            req_row(REQ_READ, 8'h00, 7'd3),
            req_row(REQ_RSVD_A, 8'h55, 7'd64),
            req_row(REQ_RSVD_B, 8'hAA, 7'd1),
            req_row(REQ_RSVD_C, 8'hFF, 7'd127),
            req_row(REQ_END, 8'h00, 7'd0),
            req_row(REQ_POP, 8'h00, 7'd1),
            // write after end input
            req_row(REQ_WRITE, 8'h5A, 7'd0),
            cap_row(11'd0),
            typed_row(REQ_WRITE, 8'h3C, 7'd0, 1'b0, 1'b1, 11'd1, 48'd4, 48'd3, 1'b1, 1'b0),
            // capacity above depth saturates
            cap_row(11'd2047),
            req_row(REQ_WRITE, 8'hC3, 7'd0),
            // capacity below the fill
            cap_row(11'd1),
            req_row(REQ_WRITE, 8'h81, 7'd0),
            req_row(REQ_POP, 8'h00, 7'd1),
            req_row(REQ_WRITE, 8'h7E, 7'd0),
            req_row(REQ_POP, 8'h00, 7'd1),
            req_row(REQ_WRITE, 8'h42, 7'd0),
            req_row(REQ_READ, 8'h00, 7'd64),
            cap_row(CAP_RESET)
        };

        foreach (plan[i])
        begin
            if (plan[i].is_cap)
                set_capacity(plan[i].cap);
            else
                offer_request(plan[i].r, plan[i].typed, plan[i].want);
        end
        directed = requests_done;

        // Random phases, each under its own capacity; the first one squeezes the output
        phase_caps = '{CAP_RESET, 11'd3, 11'd2047, 11'($urandom_range(1, 40)), 11'd0,
                       11'($urandom_range(4, 1024))};
        for (int p = 0; p < 6; p++)
        begin
            if (p > 0)
                set_capacity(phase_caps[p]);
            else
                squeeze_req = 1'b1;
            repeat (PHASE_ITEMS) offer_request(draw_request(), 1'b0, '0);
        end

        // Drain
        req_ch.valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d requests (%0d from the table) giving %0d results", requests_done,
                 directed, results_seen);
        $display("capacity rewritten %0d times; %0d mismatches", cap_writes, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### sim.f
hw/rtl/bbf_pkg.sv
hw/rtl/bbf_stream_if.sv
hw/rtl/bbf_ram.sv
hw/rtl/bbf_front.sv
hw/rtl/bbf_back.sv
hw/rtl/bounded_byte_stream_fifo_core.sv
dv/bounded_byte_stream_fifo_core_test.sv
